// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the page frame allocator RTL.
// Plain text only; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion violated");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

// ===== rtl/core/pfa_pkg.sv =====
// Package for the page frame allocator: sizes, codes, state and bus types.
// No dependencies; imported by every module of the block but pfa_ram.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int NUM_FRAMES  = 4096;
    localparam int PAGE_BYTES  = 4096;
    localparam int ADDR_W      = 64;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PFN_W       = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W       = $clog2(NUM_FRAMES);
    localparam int LINK_W      = $clog2(NUM_FRAMES + 1);
    localparam int COUNT_W     = 16;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_LSB = 3;

    // Link value that marks the end of the list; anything at or above it is null too.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_FRAMES);

    // Configuration register index.
    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_VIRTUAL_OFFSET = '0;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_FREE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_MISALIGNED = 2'd2,
        STAT_OUTSIDE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ALOAD,
        S_SWEEP
    } state_t;

    // One access to the next-pointer table.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] wdata;
    } ram_req_t;

    function automatic logic is_null(input logic [LINK_W-1:0] link);
        return link >= NULL_LINK;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pfa_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_apb.sv =====
// APB-style configuration port holding the virtual offset register.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfa_apb
    import pfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [ADDR_W-1:0]     virtual_offset
);

    logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] reg_idx;
    logic                              wr_en;
    logic [ADDR_W-1:0]                 offset_reg;
    logic [ADDR_W-1:0]                 offset_next;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        offset_next = offset_reg;
        if (wr_en && (reg_idx == REG_VIRTUAL_OFFSET))
        begin
            offset_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    assign prdata         = (reg_idx == REG_VIRTUAL_OFFSET) ? offset_reg : '0;
    assign virtual_offset = offset_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_ctrl.sv =====
// Command sequencer of the page frame allocator: list head, tail, count and
// read-modify-write of the next-pointer table. Depends on pfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic [ADDR_W-1:0]  region_base,
    input  wire logic [ADDR_W-1:0]  region_length,
    input  wire logic               region_usable,
    input  wire logic [ADDR_W-1:0]  frame_address,
    input  wire logic [ADDR_W-1:0]  virtual_offset,
    output logic                    done,
    output logic      [1:0]         status,
    output logic      [ADDR_W-1:0]  alloc_address,
    output logic      [COUNT_W-1:0] frames_in_use,
    output ram_req_t                ram_req,
    input  wire logic [LINK_W-1:0]  ram_rdata
);

    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    status_t              add_stat_reg, add_stat_next;
    logic                 done_reg;
    status_t              status_reg;
    logic [ADDR_W-1:0]    alloc_address_reg;

    cmd_t                 cmd_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    length_reg;
    logic                 usable_reg;
    logic [ADDR_W-1:0]    faddr_reg;

    logic                 accept;
    logic                 fin;
    status_t              res_status;
    logic [ADDR_W-1:0]    res_addr;

    logic                 list_empty;
    logic [PFN_W-1:0]     pfn_first;
    logic [PFN_W-1:0]     pfn_count;
    logic                 first_outside;
    logic [LINK_W-1:0]    room;
    logic                 clipped;
    logic [IDX_W-1:0]     first_idx;
    logic [IDX_W-1:0]     last_idx;
    logic [ADDR_W-1:0]    phys;
    logic [PFN_W-1:0]     free_pfn;
    logic [LINK_W-1:0]    loaded_link;

    assign accept     = start && !busy;
    assign list_empty = is_null(head_reg) || is_null(tail_reg);

    // Region decode for add region.
    assign pfn_first     = base_reg[ADDR_W-1:PAGE_SHIFT];
    assign pfn_count     = length_reg[ADDR_W-1:PAGE_SHIFT];
    assign first_outside = pfn_first >= PFN_W'(NUM_FRAMES);
    assign room          = NULL_LINK - pfn_first[LINK_W-1:0];
    assign clipped       = pfn_count > PFN_W'(room);
    assign first_idx     = pfn_first[IDX_W-1:0];
    assign last_idx      = clipped ? IDX_W'(NUM_FRAMES - 1)
                                   : first_idx + pfn_count[IDX_W-1:0] - IDX_W'(1);

    // Frame decode for free.
    assign phys     = faddr_reg - virtual_offset;
    assign free_pfn = phys[ADDR_W-1:PAGE_SHIFT];

    assign loaded_link = is_null(ram_rdata) ? NULL_LINK : ram_rdata;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fin)
                begin
                    state_next = start ? S_EXEC : S_IDLE;
                end
                else if (cmd_reg == CMD_ALLOC)
                begin
                    state_next = S_ALOAD;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end
            S_ALOAD, S_SWEEP:
            begin
                if (fin)
                begin
                    state_next = start ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs, table accesses and list updates.
    always_comb
    begin
        fin           = 1'b0;
        res_status    = STAT_OK;
        res_addr      = '0;
        ram_req.we    = 1'b0;
        ram_req.addr  = head_reg[IDX_W-1:0];
        ram_req.wdata = NULL_LINK;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        last_next     = last_reg;
        add_stat_next = add_stat_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        fin        = 1'b1;
                        head_next  = NULL_LINK;
                        tail_next  = NULL_LINK;
                        count_next = '0;
                    end
                    CMD_ADD:
                    begin
                        if (!usable_reg || (pfn_count == '0 && base_reg[PAGE_SHIFT-1:0] == '0))
                        begin
                            fin = 1'b1;
                        end
                        else if (base_reg[PAGE_SHIFT-1:0] != '0)
                        begin
                            fin        = 1'b1;
                            res_status = STAT_MISALIGNED;
                        end
                        else if (first_outside)
                        begin
                            fin        = 1'b1;
                            res_status = STAT_OUTSIDE;
                        end
                        else
                        begin
                            // Link the old tail (or head, if empty) to the first new frame, then sweep.
                            if (list_empty)
                            begin
                                head_next = LINK_W'(first_idx);
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.addr  = tail_reg[IDX_W-1:0];
                                ram_req.wdata = LINK_W'(first_idx);
                            end
                            cur_next      = first_idx;
                            last_next     = last_idx;
                            add_stat_next = clipped ? STAT_OUTSIDE : STAT_OK;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        if (is_null(head_reg))
                        begin
                            fin        = 1'b1;
                            res_status = STAT_EMPTY;
                        end
                    end
                    CMD_FREE:
                    begin
                        fin = 1'b1;
                        if (phys[PAGE_SHIFT-1:0] != '0)
                        begin
                            res_status = STAT_MISALIGNED;
                        end
                        else if (free_pfn >= PFN_W'(NUM_FRAMES))
                        begin
                            res_status = STAT_OUTSIDE;
                        end
                        else
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.addr  = free_pfn[IDX_W-1:0];
                            ram_req.wdata = head_reg;
                            if (is_null(head_reg))
                            begin
                                tail_next = LINK_W'(free_pfn[IDX_W-1:0]);
                            end
                            head_next  = LINK_W'(free_pfn[IDX_W-1:0]);
                            count_next = count_reg - COUNT_W'(1);
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_ALOAD:
            begin
                fin        = 1'b1;
                head_next  = loaded_link;
                if (is_null(loaded_link))
                begin
                    tail_next = NULL_LINK;
                end
                count_next = count_reg + COUNT_W'(1);
                res_addr   = (ADDR_W'(head_reg[IDX_W-1:0]) << PAGE_SHIFT) + virtual_offset;
            end
            S_SWEEP:
            begin
                ram_req.we   = 1'b1;
                ram_req.addr = cur_reg;
                if (cur_reg == last_reg)
                begin
                    fin           = 1'b1;
                    res_status    = add_stat_reg;
                    ram_req.wdata = NULL_LINK;
                    tail_next     = LINK_W'(last_reg);
                end
                else
                begin
                    ram_req.wdata = LINK_W'(cur_reg) + LINK_W'(1);
                    cur_next      = cur_reg + IDX_W'(1);
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
        busy = !((state_reg == S_IDLE) || fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= NULL_LINK;
            tail_reg     <= NULL_LINK;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            cur_reg      <= '0;
            last_reg     <= '0;
            add_stat_reg <= STAT_OK;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            done_reg     <= fin;
            cur_reg      <= cur_next;
            last_reg     <= last_next;
            add_stat_reg <= add_stat_next;
        end
    end

    // Command beat and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            base_reg   <= region_base;
            length_reg <= region_length;
            usable_reg <= region_usable;
            faddr_reg  <= frame_address;
        end
        if (fin)
        begin
            status_reg        <= res_status;
            alloc_address_reg <= res_addr;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_address = alloc_address_reg;
    assign frames_in_use = count_reg;

    // While a region is being linked onto an empty list the tail trails the head.
    `ASSERT_IMPLY(a_head_tail_null, clk, rst_n, state_reg != S_SWEEP, is_null(head_reg) == is_null(tail_reg))
    `ASSERT_NEXT(a_aload_done, clk, rst_n, state_reg == S_ALOAD, done_reg)
    `ASSERT_IMPLY(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !ram_req.we)
    `ASSERT_IMPLY(a_count_on_done, clk, rst_n, count_reg != $past(count_reg), done_reg)

endmodule

`default_nettype wire

// ===== rtl/core/page_frame_free_list_allocator.sv =====
// Top level of the page frame allocator: config port, sequencer and link table.
// Depends on pfa_pkg, pfa_apb, pfa_ctrl and pfa_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A command beat is taken at a rising edge where start is high and busy is
// low; command selects start, add region, allocate or free, and the other
// input ports carry that command's operands. Every command yields exactly
// one result beat: done is high for one cycle while status, alloc_address
// and frames_in_use hold the result. The receiver cannot stall, so results
// are never held back; it must take each beat in its cycle.
// Done is registered from the state a command finishes in. Start, free and any
// rejected command finish in the execute state; allocate issues its table
// read there and finishes in the load state behind the registered read port;
// add region then sweeps, as the single table port writes one link per cycle.
// Busy drops in the final cycle of a command, so a new command may be taken
// on the edge that completes the previous one: start and free sustain one
// command per cycle, while an allocate keeps busy high until its read returns.
// The virtual offset is written through the APB port at byte address 0 and
// must only change while the block is idle.
// Reset empties the list, clears the in-use count and the offset. The link
// table is not cleared; the list never reaches an entry it has not written.

module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            command,
    input  wire logic [ADDR_W-1:0]     region_base,
    input  wire logic [ADDR_W-1:0]     region_length,
    input  wire logic                  region_usable,
    input  wire logic [ADDR_W-1:0]     frame_address,
    output logic                       done,
    output logic      [1:0]            status,
    output logic      [ADDR_W-1:0]     alloc_address,
    output logic      [COUNT_W-1:0]    frames_in_use,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [ADDR_W-1:0] virtual_offset;
    ram_req_t          ram_req;
    logic [LINK_W-1:0] ram_rdata;

    // Configuration register.
    pfa_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .virtual_offset (virtual_offset)
    );

    // Command sequencer; owns head, tail and the in-use count.
    pfa_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .region_base    (region_base),
        .region_length  (region_length),
        .region_usable  (region_usable),
        .frame_address  (frame_address),
        .virtual_offset (virtual_offset),
        .done           (done),
        .status         (status),
        .alloc_address  (alloc_address),
        .frames_in_use  (frames_in_use),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata)
    );

    // Next-pointer table, one link per frame number.
    pfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_FRAMES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== bench/page_frame_free_list_allocator_tb.sv =====
// Self-checking bench for the page frame allocator: directed corner commands first,
// then phases of random command streams checked against a free list mirror in the bench.
// Depends on pfa_pkg and the page_frame_free_list_allocator RTL; reads no files.
`timescale 1ns / 1ps

module page_frame_free_list_allocator_tb;
    import pfa_pkg::*;

    localparam int TOTAL_ITEMS = 2000;
    localparam int PHASES      = 6;
    // Longest quiet stretch in a correct run is an add that links the whole table
    // (one link per frame) plus a long sender gap; take that several times over.
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
    localparam logic [ADDR_W-1:0] TOP_PAGE  = ALL_ONES & ~PAGE_MASK;

    // One command beat as the sender presents it.
    typedef struct {
        cmd_t              op;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic              usable;
        logic [ADDR_W-1:0] frame;
    } command_beat_t;

    // One result beat as the block should return it.
    typedef struct {
        status_t            status;
        logic [ADDR_W-1:0]  vaddr;
        logic [COUNT_W-1:0] in_use;
    } result_beat_t;

    // Mirror of the free list. Every accepted command is applied here in order of
    // acceptance, and the result it should produce is queued until its beat arrives.
    class free_list_mirror;
        logic [LINK_W-1:0]  next_link [NUM_FRAMES];
        logic [LINK_W-1:0]  head;
        logic [LINK_W-1:0]  tail;
        logic [COUNT_W-1:0] in_use;
        logic [ADDR_W-1:0]  offset;
        result_beat_t       awaited[$];
        int                 errors;

        function new();
            head   = NULL_LINK;
            tail   = NULL_LINK;
            in_use = '0;
            offset = '0;
            errors = 0;
        endfunction

        // Link one frame behind the current tail.
        function void push_tail(logic [IDX_W-1:0] f);
            next_link[f] = NULL_LINK;
            if (tail >= NULL_LINK || head >= NULL_LINK)
                head = LINK_W'(f);
            else
                next_link[tail[IDX_W-1:0]] = LINK_W'(f);
            tail = LINK_W'(f);
        endfunction

        // Append the whole pages of a region; pages past the table are dropped.
        function status_t link_region(command_beat_t c);
            logic [ADDR_W-1:0] page_lo;
            logic [ADDR_W-1:0] pages;
            logic [ADDR_W-1:0] page_hi;
            logic [ADDR_W-1:0] f;
            status_t           st;
            st = STAT_OK;
            if (!c.usable)
                return STAT_OK;
            if ((c.base & PAGE_MASK) != 0)
                return STAT_MISALIGNED;
            page_lo = c.base >> PAGE_SHIFT;
            pages   = c.length >> PAGE_SHIFT;
            if (pages == 0)
                return STAT_OK;
            if (page_lo >= ADDR_W'(NUM_FRAMES))
                return STAT_OUTSIDE;
            if (pages > ADDR_W'(NUM_FRAMES) - page_lo)
            begin
                page_hi = ADDR_W'(NUM_FRAMES);
                st      = STAT_OUTSIDE;
            end
            else
            begin
                page_hi = page_lo + pages;
            end
            for (f = page_lo; f < page_hi; f++)
                push_tail(IDX_W'(f));
            return st;
        endfunction

        // Apply an accepted command and queue the result it should produce.
        function result_beat_t take_command(command_beat_t c);
            result_beat_t      r;
            logic [ADDR_W-1:0] phys;
            logic [IDX_W-1:0]  f;
            r.status = STAT_OK;
            r.vaddr  = '0;
            case (c.op)
                CMD_START:
                begin
                    head   = NULL_LINK;
                    tail   = NULL_LINK;
                    in_use = '0;
                end
                CMD_ADD:
                begin
                    r.status = link_region(c);
                end
                CMD_ALLOC:
                begin
                    if (head >= NULL_LINK)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        f    = head[IDX_W-1:0];
                        head = (next_link[f] >= NULL_LINK) ? NULL_LINK : next_link[f];
                        // Popping the last frame leaves no tail behind.
                        if (head == NULL_LINK)
                            tail = NULL_LINK;
                        in_use  = in_use + COUNT_W'(1);
                        r.vaddr = (ADDR_W'(f) << PAGE_SHIFT) + offset;
                    end
                end
                CMD_FREE:
                begin
                    phys = c.frame - offset;
                    if ((phys & PAGE_MASK) != 0)
                    begin
                        r.status = STAT_MISALIGNED;
                    end
                    else if ((phys >> PAGE_SHIFT) >= ADDR_W'(NUM_FRAMES))
                    begin
                        r.status = STAT_OUTSIDE;
                    end
                    else
                    begin
                        f            = IDX_W'(phys >> PAGE_SHIFT);
                        next_link[f] = head;
                        // A frame pushed onto an empty list is also its tail.
                        if (head >= NULL_LINK)
                            tail = LINK_W'(f);
                        head   = LINK_W'(f);
                        in_use = in_use - COUNT_W'(1);
                    end
                end
                default:
                begin
                    r.status = STAT_OK;
                end
            endcase
            r.in_use = in_use;
            awaited.push_back(r);
            return r;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("ERROR at %0t ns: %s", $time, what);
        endtask

        // Compare one result beat with the oldest outstanding expectation.
        task match_result(logic [1:0] st, logic [ADDR_W-1:0] va, logic [COUNT_W-1:0] cnt);
            result_beat_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing outstanding (status %0d)", st));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
            if (va !== want.vaddr)
                report_mismatch($sformatf("alloc_address %h, expected %h", va, want.vaddr));
            if (cnt !== want.in_use)
                report_mismatch($sformatf("frames_in_use %0d, expected %0d", cnt, want.in_use));
        endtask
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  start         = 1'b0;
    logic [1:0]            command       = CMD_START;
    logic [ADDR_W-1:0]     region_base   = '0;
    logic [ADDR_W-1:0]     region_length = '0;
    logic                  region_usable = 1'b0;
    logic [ADDR_W-1:0]     frame_address = '0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic                  busy;
    logic                  done;
    logic [1:0]            status;
    logic [ADDR_W-1:0]     alloc_address;
    logic [COUNT_W-1:0]    frames_in_use;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    free_list_mirror  mirror = new();
    // Frames the bench believes are handed out; frees are mostly drawn from here.
    logic [IDX_W-1:0] live_frames[$];
    int               quiet_cycles = 0;

    page_frame_free_list_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .region_base   (region_base),
        .region_length (region_length),
        .region_usable (region_usable),
        .frame_address (frame_address),
        .done          (done),
        .status        (status),
        .alloc_address (alloc_address),
        .frames_in_use (frames_in_use),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result beats last one cycle and cannot be held off, so the monitor samples
    // done at every rising edge. Values read here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.match_result(status, alloc_address, frames_in_use);
    end

    // Watchdog: any command, result or register beat counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("page_frame_free_list_allocator: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] frame_vaddr(input logic [IDX_W-1:0] f);
        return (ADDR_W'(f) << PAGE_SHIFT) + mirror.offset;
    endfunction

    function automatic command_beat_t make_command(input cmd_t op,
                                                   input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] length,
                                                   input logic usable,
                                                   input logic [ADDR_W-1:0] frame);
        command_beat_t c;
        c.op     = op;
        c.base   = base;
        c.length = length;
        c.usable = usable;
        c.frame  = frame;
        return c;
    endfunction

    // Random command. Most beats form a working allocator session: small regions
    // added inside the table, allocations, and frees of frames actually handed out.
    // The rest is noise: bad frees, bad regions, regions running off the table.
    // Operands that the command ignores still carry random values.
    function automatic command_beat_t pick_command();
        command_beat_t     c;
        logic [ADDR_W-1:0] phys;
        int                r;
        int                idx;
        c.op     = cmd_t'($urandom_range(3));
        c.base   = {$urandom, $urandom};
        c.length = {$urandom, $urandom};
        c.usable = 1'($urandom_range(1));
        c.frame  = {$urandom, $urandom};
        r        = $urandom_range(99);
        if (r < 3)
        begin
            c.op = CMD_START;
        end
        else if (r < 30)
        begin
            c.op     = CMD_ADD;
            c.usable = ($urandom_range(19) != 0);
            c.base   = ADDR_W'($urandom_range(NUM_FRAMES - 1)) << PAGE_SHIFT;
            c.length = ADDR_W'($urandom_range(8)) * PAGE_BYTES
                     + ADDR_W'($urandom_range(PAGE_BYTES - 1));
        end
        else if (r < 58 || (r < 86 && live_frames.size() == 0))
        begin
            c.op = CMD_ALLOC;
        end
        else if (r < 86)
        begin
            idx     = $urandom_range(live_frames.size() - 1);
            c.op    = CMD_FREE;
            c.frame = frame_vaddr(live_frames[idx]);
            live_frames.delete(idx);
        end
        else
        begin
            case ($urandom_range(5))
                0:
                begin
                    // Fully random beat of a random command.
                end
                1:
                begin
                    c.op    = CMD_FREE;
                    c.frame = frame_vaddr(IDX_W'($urandom_range(NUM_FRAMES - 1)))
                            + ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
                end
                2:
                begin
                    // Page aligned but beyond the table, sometimes right at its end.
                    if ($urandom_range(3) == 0)
                        phys = ADDR_W'(NUM_FRAMES) << PAGE_SHIFT;
                    else
                        phys = ({$urandom, $urandom} | (ADDR_W'(NUM_FRAMES) << PAGE_SHIFT))
                             & ~PAGE_MASK;
                    c.op    = CMD_FREE;
                    c.frame = phys + mirror.offset;
                end
                3:
                begin
                    // Free of any frame in the table, often one already on the list.
                    c.op    = CMD_FREE;
                    c.frame = frame_vaddr(IDX_W'($urandom_range(NUM_FRAMES - 1)));
                end
                4:
                begin
                    c.op = CMD_ADD;
                    if ($urandom_range(1))
                        c.base = c.base & ~PAGE_MASK;
                    if ($urandom_range(1))
                        c.length = ADDR_W'($urandom_range(3 * PAGE_BYTES));
                end
                default:
                begin
                    // Region that runs past the last frame; now and then from low down.
                    c.op     = CMD_ADD;
                    c.usable = 1'b1;
                    if ($urandom_range(9) == 0)
                        c.base = ADDR_W'($urandom_range(NUM_FRAMES - 1)) << PAGE_SHIFT;
                    else
                        c.base = ADDR_W'($urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 16))
                               << PAGE_SHIFT;
                end
            endcase
        end
        return c;
    endfunction

    // Present one command beat and hold it until the block takes it. A beat is
    // taken at an edge where start is high and busy is low; busy is read right
    // after the edge, before the block's own updates land. The sender then idles
    // for a random number of cycles, or keeps start high for the next beat.
    task automatic send_command(input command_beat_t c, input int idle_pct);
        result_beat_t due;
        start         <= 1'b1;
        command       <= c.op;
        region_base   <= c.base;
        region_length <= c.length;
        region_usable <= c.usable;
        frame_address <= c.frame;
        do @(posedge clk); while (busy);
        due = mirror.take_command(c);
        if (c.op == CMD_START)
            live_frames.delete();
        else if (c.op == CMD_ALLOC && due.status == STAT_OK)
            live_frames.push_back(IDX_W'((due.vaddr - mirror.offset) >> PAGE_SHIFT));
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding result beat has arrived.
    task automatic settle();
        start <= 1'b0;
        while (mirror.awaited.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of the offset register: setup cycle, then access until pready.
    task automatic write_offset(input logic [ADDR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_VIRTUAL_OFFSET) << CFG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mirror.offset = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Corner commands, run with the offset at its reset value of zero.
    task automatic run_directed();
        // Allocate from the empty list after reset.
        send_command(make_command(CMD_ALLOC, '0, '0, 1'b0, '0), 9);
        // Free onto an empty list: the count wraps below zero, then back up to zero.
        send_command(make_command(CMD_FREE, ALL_ONES, ALL_ONES, 1'b1, '0), 9);
        send_command(make_command(CMD_ALLOC, '0, '0, 1'b0, ALL_ONES), 9);
        // Frees that are misaligned, far outside and just outside the table.
        send_command(make_command(CMD_FREE, '0, '0, 1'b0, ALL_ONES), 9);
        send_command(make_command(CMD_FREE, '0, '0, 1'b0, TOP_PAGE), 9);
        send_command(make_command(CMD_FREE, '0, '0, 1'b0,
                                  ADDR_W'(NUM_FRAMES) << PAGE_SHIFT), 9);
        // Unusable, misaligned, zero-page and out-of-table regions add nothing.
        send_command(make_command(CMD_ADD, '0, ADDR_W'(16 * PAGE_BYTES), 1'b0, '0), 9);
        send_command(make_command(CMD_ADD, ALL_ONES, ALL_ONES, 1'b1, '0), 9);
        send_command(make_command(CMD_ADD, '0, ADDR_W'(PAGE_BYTES - 1), 1'b1, '0), 9);
        send_command(make_command(CMD_ADD, ADDR_W'(NUM_FRAMES) << PAGE_SHIFT,
                                  ADDR_W'(PAGE_BYTES), 1'b1, '0), 9);
        send_command(make_command(CMD_ADD, TOP_PAGE, '0, 1'b1, '0), 9);
        // Region running off the end links its last three frames only.
        send_command(make_command(CMD_ADD, ADDR_W'(NUM_FRAMES - 3) << PAGE_SHIFT,
                                  ALL_ONES, 1'b1, '0), 9);
        // Two whole pages plus a fragment at the bottom of memory.
        send_command(make_command(CMD_ADD, '0, ADDR_W'(2 * PAGE_BYTES + 100), 1'b1, '0), 9);
        // Drain the list in order, then hit empty again.
        repeat (6)
            send_command(make_command(CMD_ALLOC, '0, '0, 1'b0, '0), 9);
        // Freeing the same frame twice links it to itself.
        send_command(make_command(CMD_FREE, '0, '0, 1'b0,
                                  ADDR_W'(NUM_FRAMES - 1) << PAGE_SHIFT), 9);
        send_command(make_command(CMD_FREE, '0, '0, 1'b0,
                                  ADDR_W'(NUM_FRAMES - 1) << PAGE_SHIFT), 9);
        send_command(make_command(CMD_ALLOC, '0, '0, 1'b0, '0), 9);
        // Start over, link the whole table from one huge region, start over again.
        send_command(make_command(CMD_START, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES), 9);
        send_command(make_command(CMD_ADD, '0, ALL_ONES, 1'b1, '0), 9);
        send_command(make_command(CMD_START, '0, '0, 1'b0, '0), 9);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] offset_value;
        int                idle_pct;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Random phases. The sender idles rarely in the first two, heavily in the
        // middle two and never in the last two; the offset changes each phase,
        // only once the block has gone quiet.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       offset_value = '0;
                1:       offset_value = ALL_ONES;
                2:       offset_value = {$urandom, $urandom} & ~PAGE_MASK;
                4:       offset_value = {1'b1, {(ADDR_W - 1){1'b0}}};
                default: offset_value = {$urandom, $urandom};
            endcase
            idle_pct = (p < 2) ? 9 : (p < 4) ? 73 : 0;
            settle();
            write_offset(offset_value);
            for (int i = 0; i < TOTAL_ITEMS / PHASES; i++)
                send_command(pick_command(), idle_pct);
        end

        // Let the last beats come home, then watch a little longer for strays.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("page_frame_free_list_allocator: match");
        else
            $display("page_frame_free_list_allocator: mismatch");
        $finish;
    end

endmodule
